// ===== hw/rtl/range_set_subtract_unit_macros.svh =====
// Assertion macros shared by the checker of the range set subtract unit.
`ifndef RANGE_SET_SUBTRACT_UNIT_MACROS_SVH
`define RANGE_SET_SUBTRACT_UNIT_MACROS_SVH

// Implication in the same cycle, ignored while reset is high.
`define RSS_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication into the next cycle, ignored while reset is high.
`define RSS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Implication into the next cycle that also holds across reset.
`define RSS_ASSERT_NEXT_RST(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/rss_pkg.sv =====
package rss_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int RES_DEPTH   = 4;
  localparam int RES_PTR_W   = $clog2(RES_DEPTH);
  localparam int RES_CNT_W   = $clog2(RES_DEPTH + 1);

  localparam logic FUNC_BEGIN    = 1'b0;
  localparam logic FUNC_SUBTRACT = 1'b1;

  typedef struct packed {
    logic [VALUE_WIDTH-1:0] out_low;
    logic [VALUE_WIDTH-1:0] out_high;
    logic                   has_piece;
    logic                   end_of_call;
  } rss_result_t;

  // Results of one item: count is 0, 1 or 2, r0 is always filled first.
  typedef struct packed {
    logic [1:0]  count;
    rss_result_t r0;
    rss_result_t r1;
  } rss_push_t;

endpackage

// ===== hw/rtl/rss_req_if.sv =====
interface rss_req_if import rss_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   func;
  logic [VALUE_WIDTH-1:0] range_low;
  logic [VALUE_WIDTH-1:0] range_high;
  logic                   last_item;

  modport source (output valid, func, range_low, range_high, last_item, input ready);
  modport sink (input valid, func, range_low, range_high, last_item, output ready);
endinterface

// ===== hw/rtl/rss_rsp_if.sv =====
interface rss_rsp_if import rss_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] out_low;
  logic [VALUE_WIDTH-1:0] out_high;
  logic                   has_piece;
  logic                   end_of_call;

  modport source (output valid, out_low, out_high, has_piece, end_of_call, input ready);
  modport sink (input valid, out_low, out_high, has_piece, end_of_call, output ready);
endinterface

// ===== hw/rtl/rss_engine.sv =====
module rss_engine import rss_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  rss_req_if.sink   req,
  input  logic      room,
  output rss_push_t push
);

  logic                   item_valid;
  logic                   item_func;
  logic [VALUE_WIDTH-1:0] item_low;
  logic [VALUE_WIDTH-1:0] item_high;
  logic                   item_last;

  logic [VALUE_WIDTH-1:0] running_low;
  logic [VALUE_WIDTH-1:0] target_high;
  logic                   exhausted;

  logic [VALUE_WIDTH-1:0] running_low_next;
  logic [VALUE_WIDTH-1:0] target_high_next;
  logic                   exhausted_next;

  logic                   advance;
  logic                   gap;
  logic [VALUE_WIDTH-1:0] low_m1;
  logic [VALUE_WIDTH-1:0] gap_high;
  logic [VALUE_WIDTH-1:0] bound;
  rss_result_t            gap_res;
  rss_result_t            final_res;

  assign advance   = item_valid && room;
  assign req.ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (req.ready) begin
      item_valid <= req.valid;
    end
    if (req.valid && req.ready) begin
      item_func <= req.func;
      item_low  <= req.range_low;
      item_high <= req.range_high;
      item_last <= req.last_item;
    end
  end

  always_comb begin
    low_m1   = item_low - VALUE_WIDTH'(1);
    gap_high = (low_m1 > target_high) ? target_high : low_m1;
    bound    = item_high + VALUE_WIDTH'(1);
    gap      = 1'b0;

    running_low_next = running_low;
    target_high_next = target_high;
    exhausted_next   = exhausted;

    if (item_func == FUNC_BEGIN) begin
      running_low_next = item_low;
      target_high_next = item_high;
      exhausted_next   = item_low > item_high;
    end else if (!exhausted) begin
      gap = running_low < item_low;
      if (item_high == '1) begin
        exhausted_next = 1'b1;
      end else begin
        if (bound > running_low) begin
          running_low_next = bound;
        end
        exhausted_next = ((bound > running_low) ? bound : running_low) > target_high;
      end
    end

    gap_res.out_low     = running_low;
    gap_res.out_high    = gap_high;
    gap_res.has_piece   = 1'b1;
    gap_res.end_of_call = 1'b0;

    if (exhausted_next) begin
      final_res.out_low   = '0;
      final_res.out_high  = '0;
      final_res.has_piece = 1'b0;
    end else begin
      final_res.out_low   = running_low_next;
      final_res.out_high  = target_high_next;
      final_res.has_piece = 1'b1;
    end
    final_res.end_of_call = 1'b1;

    push.r0    = gap ? gap_res : final_res;
    push.r1    = final_res;
    push.count = advance ? (2'(gap) + 2'(item_last)) : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_low <= '0;
      target_high <= '0;
      exhausted   <= 1'b1;
    end else if (advance) begin
      running_low <= running_low_next;
      target_high <= target_high_next;
      exhausted   <= exhausted_next || item_last;
    end
  end

endmodule

// ===== hw/rtl/rss_result_queue.sv =====
module rss_result_queue import rss_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  rss_push_t push,
  output logic      room,
  rss_rsp_if.source rsp
);

  rss_result_t            slots [RES_DEPTH];
  logic [RES_PTR_W-1:0]   wr_ptr;
  logic [RES_PTR_W-1:0]   rd_ptr;
  logic [RES_CNT_W-1:0]   count;
  logic                   pop;
  rss_result_t            head;

  assign room = count <= RES_CNT_W'(RES_DEPTH - 2);
  assign pop  = rsp.valid && rsp.ready;
  assign head = slots[rd_ptr];

  assign rsp.valid       = count != '0;
  assign rsp.out_low     = head.out_low;
  assign rsp.out_high    = head.out_high;
  assign rsp.has_piece   = head.has_piece;
  assign rsp.end_of_call = head.end_of_call;

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      slots[wr_ptr] <= push.r0;
    end
    if (push.count == 2'd2) begin
      slots[wr_ptr + RES_PTR_W'(1)] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + RES_PTR_W'(push.count);
      rd_ptr <= rd_ptr + RES_PTR_W'(pop);
      count  <= count + RES_CNT_W'(push.count) - RES_CNT_W'(pop);
    end
  end

endmodule

// ===== hw/rtl/range_set_subtract_unit.sv =====
// Range set subtract unit. A begin transfer (func = 0) loads a closed target
// range [range_low, range_high]. Each subtract transfer (func = 1) carries one
// range of a list that must be sorted ascending and non-overlapping; for each
// one the unit sends the gap of the target below it, if any, as a result with
// has_piece = 1 and end_of_call = 0, and then moves its running low bound past
// the range. A list range whose high end is the largest value uses up the
// target instead of wrapping around. A transfer with last_item = 1 also sends
// the final result with end_of_call = 1: the rest of the target, or a result
// with has_piece = 0 and zero bounds when nothing is left. After that final
// result the target counts as used up, so further list items send nothing
// until the next begin, except that a last item still sends an empty final.
// Each input transfer therefore causes zero, one or two results, in order.
// The request is held in an input register, its results are computed
// combinationally and written into a four-entry result queue; the unit takes
// one input transfer per clock while the queue has room. The first result is
// visible once the input register has passed it into the result queue, ready
// to be taken at the following edge. The output port delivers one result per
// clock while the receiver is ready, two results of one item one after the
// other; the request side stalls only when the queue cannot hold two more results.
module range_set_subtract_unit import rss_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  rss_req_if.sink   req,
  rss_rsp_if.source rsp
);

  // Results of the item leaving the input register this cycle.
  rss_push_t push;
  // The queue has space for the largest burst one item can produce.
  logic      room;

  rss_engine u_engine (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .room (room),
    .push (push)
  );

  rss_result_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .room (room),
    .rsp  (rsp)
  );

endmodule

// ===== hw/rtl/rss_checker.sv =====
`include "range_set_subtract_unit_macros.svh"

module rss_checker import rss_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   rsp_valid,
  input logic                   rsp_ready,
  input logic [VALUE_WIDTH-1:0] out_low,
  input logic [VALUE_WIDTH-1:0] out_high,
  input logic                   has_piece,
  input logic                   end_of_call
);

  `RSS_ASSERT_NEXT_RST(a_idle_after_reset, clk, rst, !rsp_valid, "result valid after reset")

  `RSS_ASSERT_IMPL(a_empty_is_final, clk, rst, rsp_valid && !has_piece,
    end_of_call && out_low == '0 && out_high == '0, "empty result is malformed")

  `RSS_ASSERT_IMPL(a_piece_ordered, clk, rst, rsp_valid && has_piece,
    out_low <= out_high, "piece with low above high")

  `RSS_ASSERT_NEXT(a_stall_holds, clk, rst, rsp_valid && !rsp_ready,
    rsp_valid && $stable({out_low, out_high, has_piece, end_of_call}),
    "stalled result changed")

endmodule

bind range_set_subtract_unit rss_checker u_rss_checker (
  .clk         (clk),
  .rst         (rst),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .out_low     (rsp.out_low),
  .out_high    (rsp.out_high),
  .has_piece   (rsp.has_piece),
  .end_of_call (rsp.end_of_call)
);

// ===== dv/range_set_subtract_unit_test.sv =====
module range_set_subtract_unit_test;
  import rss_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Run length and pacing limits.
  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 120;
  localparam int DRAIN_CYCLES = 16;
  localparam int PRINT_LIMIT  = 40;

  localparam logic [VALUE_WIDTH-1:0] VALUE_MAX = '1;

  // One extra bit so that range arithmetic in the generator never wraps.
  typedef logic [VALUE_WIDTH:0] wide_t;

  // One request as the generator builds it and the driver sends it.
  typedef struct {
    logic                   func;
    logic [VALUE_WIDTH-1:0] low;
    logic [VALUE_WIDTH-1:0] high;
    logic                   last;
  } range_item_t;

  // How the two sides of the block are paced during a phase.
  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  logic clk;
  logic rst;

  rss_req_if req_ch ();
  rss_rsp_if rsp_ch ();

  range_set_subtract_unit i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // Requests waiting to be driven, and the results that the accepted requests
  // are predicted to produce, oldest first.
  range_item_t range_queue[$];
  rss_result_t pending_pieces[$];

  // Shadow of the block's state, advanced once per accepted request.
  logic [VALUE_WIDTH-1:0] run_low;
  logic [VALUE_WIDTH-1:0] tgt_high;
  logic                   used_up;

  int          error_count;
  int          cycle_count;
  int          items_made;
  int          tx_idle_pct;
  int          rx_stall_pct;
  int          hold_left;
  bit          hold_trigger;
  range_item_t next_item;
  rss_result_t want_piece;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= PRINT_LIMIT) begin
      $display("ERROR at %0t ns: %s", $time, msg);
    end
  endtask

  // Works out the results of one accepted request and queues them. A begin
  // request loads the target; a subtract request sends the gap below its
  // range and then pushes the running low bound past the range. A range
  // that ends at the largest value uses the target up rather than wrapping.
  // A request marked last always adds the final result, which is the rest
  // of the target or an empty result with zero bounds.
  function automatic void predict_pieces(input range_item_t it);
    logic [VALUE_WIDTH-1:0] gap_high;
    logic [VALUE_WIDTH-1:0] past_high;
    rss_result_t            piece;
    if (it.func == FUNC_BEGIN) begin
      run_low  = it.low;
      tgt_high = it.high;
      used_up  = it.low > it.high;
    end else if (!used_up) begin
      if (run_low < it.low) begin
        gap_high = it.low - 1'b1;
        if (gap_high > tgt_high) begin
          gap_high = tgt_high;
        end
        piece.out_low     = run_low;
        piece.out_high    = gap_high;
        piece.has_piece   = 1'b1;
        piece.end_of_call = 1'b0;
        pending_pieces = {pending_pieces, piece};
      end
      if (it.high == VALUE_MAX) begin
        used_up = 1'b1;
      end else begin
        // A reversed range still moves the bound, but never backwards.
        past_high = it.high + 1'b1;
        if (past_high > run_low) begin
          run_low = past_high;
        end
        if (run_low > tgt_high) begin
          used_up = 1'b1;
        end
      end
    end
    if (it.last) begin
      piece.end_of_call = 1'b1;
      if (!used_up) begin
        piece.out_low   = run_low;
        piece.out_high  = tgt_high;
        piece.has_piece = 1'b1;
      end else begin
        piece.out_low   = '0;
        piece.out_high  = '0;
        piece.has_piece = 1'b0;
      end
      pending_pieces = {pending_pieces, piece};
      used_up = 1'b1;
    end
  endfunction

  task automatic queue_range(input logic func, input logic [VALUE_WIDTH-1:0] low,
                             input logic [VALUE_WIDTH-1:0] high, input logic last);
    range_item_t it;
    it.func = func;
    it.low  = low;
    it.high = high;
    it.last = last;
    range_queue = {range_queue, it};
    items_made++;
  endtask

  // Builds one subtraction call: a begin request followed by a sorted list of
  // disjoint ranges around the target, the final one marked last. Most calls
  // use small values so that the ranges overlap the target in every way;
  // some sit just under the largest value, some spread over the full width.
  // A broken call reverses or scrambles one request, or never ends its list.
  task automatic add_call(input bit broken);
    range_item_t calls[$];
    range_item_t it;
    wide_t       base, span, step, t_lo, t_hi, pos, lo, hi;
    logic [VALUE_WIDTH-1:0] swap;
    int          count, k, back;
    bit          drop_last;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: begin
        base = '0;
        span = wide_t'(256);
        step = wide_t'(40);
      end
      6, 7: begin
        base = wide_t'(VALUE_MAX) - wide_t'(400);
        span = wide_t'(300);
        step = wide_t'(60);
      end
      default: begin
        base = '0;
        span = 33'h0_7fff_ffff;
        step = 33'h0_1fff_ffff;
      end
    endcase
    t_lo = base + wide_t'($urandom_range(0, 32'(span)));
    t_hi = t_lo + wide_t'($urandom_range(0, 32'(span)));
    if (t_hi > wide_t'(VALUE_MAX)) begin
      t_hi = wide_t'(VALUE_MAX);
    end
    it.func = FUNC_BEGIN;
    it.last = 1'b0;
    if ($urandom_range(0, 11) == 0) begin
      // Empty target: low end above high end.
      it.low  = t_hi[VALUE_WIDTH-1:0];
      it.high = VALUE_WIDTH'(t_lo - wide_t'(1));
    end else begin
      it.low  = t_lo[VALUE_WIDTH-1:0];
      it.high = t_hi[VALUE_WIDTH-1:0];
    end
    calls = {calls, it};

    // The list may start somewhat below the target.
    back = int'($urandom_range(0, 32'(step)));
    pos  = (t_lo >= wide_t'(back)) ? t_lo - wide_t'(back) : '0;
    count = int'($urandom_range(0, 6));
    repeat (count) begin
      lo = pos + wide_t'($urandom_range(0, 32'(step)));
      if (lo > wide_t'(VALUE_MAX)) begin
        break;
      end
      hi = lo + wide_t'($urandom_range(0, 32'(step)));
      if (hi > wide_t'(VALUE_MAX) || $urandom_range(0, 15) == 0) begin
        hi = wide_t'(VALUE_MAX);
      end
      it.func = FUNC_SUBTRACT;
      it.low  = lo[VALUE_WIDTH-1:0];
      it.high = hi[VALUE_WIDTH-1:0];
      calls = {calls, it};
      pos = hi + wide_t'(1);
    end

    drop_last = 1'b0;
    if (broken) begin
      k = int'($urandom_range(0, calls.size() - 1));
      case ($urandom_range(0, 2))
        0: begin
          swap          = calls[k].low;
          calls[k].low  = calls[k].high;
          calls[k].high = swap;
        end
        1: begin
          calls[k].low  = $urandom;
          calls[k].high = $urandom;
        end
        default: drop_last = 1'b1;
      endcase
    end
    if (!drop_last) begin
      calls[calls.size() - 1].last = 1'b1;
    end
    foreach (calls[i]) begin
      queue_range(calls[i].func, calls[i].low, calls[i].high, calls[i].last);
    end
  endtask

  // Fills the request queue with about the given number of requests: mostly
  // well-formed calls, some broken ones and short bursts of pure noise.
  task automatic fill_phase(input int target_items);
    int start;
    int pick;
    start = items_made;
    while (items_made - start < target_items) begin
      pick = int'($urandom_range(0, 9));
      if (pick < 8) begin
        add_call(1'b0);
      end else if (pick == 8) begin
        add_call(1'b1);
      end else begin
        repeat ($urandom_range(1, 3)) begin
          queue_range(1'($urandom_range(0, 1)), $urandom, $urandom,
                      $urandom_range(0, 3) == 0);
        end
      end
    end
  endtask

  task automatic set_idle(input idle_mode_t mode);
    tx_idle_pct  = (mode == IDLE_SENDER)   ? 45 : (mode == IDLE_BOTH) ? 18 : 0;
    rx_stall_pct = (mode == IDLE_RECEIVER) ? 45 : (mode == IDLE_BOTH) ? 18 : 0;
  endtask

  // Holds the sender back until every queued request has been sent and every
  // predicted result has come out. Sampled on the falling edge, away from the
  // clocked processes that move the queues.
  task automatic wait_drained();
    while (range_queue.size() != 0 || req_ch.valid || pending_pieces.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // Driver. A request that is offered stays on the bus until its transfer;
  // each transfer is passed to the predictor with the values that were on
  // the bus at that edge.
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        next_item.func = req_ch.func;
        next_item.low  = req_ch.range_low;
        next_item.high = req_ch.range_high;
        next_item.last = req_ch.last_item;
        predict_pieces(next_item);
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (range_queue.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
          next_item = range_queue.pop_front();
          req_ch.func       <= next_item.func;
          req_ch.range_low  <= next_item.low;
          req_ch.range_high <= next_item.high;
          req_ch.last_item  <= next_item.last;
          req_ch.valid      <= 1'b1;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted here so that the driver keeps offering
  // requests while the block's result queue fills and it stops taking input.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_trigger) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor. Every result transfer is matched against the oldest prediction,
  // field by field; ready is then redrawn for the next edge.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (pending_pieces.size() == 0) begin
          report_mismatch($sformatf("result [%h, %h] piece %b end %b with none expected",
                                    rsp_ch.out_low, rsp_ch.out_high, rsp_ch.has_piece,
                                    rsp_ch.end_of_call));
        end else begin
          want_piece = pending_pieces.pop_front();
          if (rsp_ch.out_low !== want_piece.out_low) begin
            report_mismatch($sformatf("out_low %h, expected %h",
                                      rsp_ch.out_low, want_piece.out_low));
          end
          if (rsp_ch.out_high !== want_piece.out_high) begin
            report_mismatch($sformatf("out_high %h, expected %h",
                                      rsp_ch.out_high, want_piece.out_high));
          end
          if (rsp_ch.has_piece !== want_piece.has_piece) begin
            report_mismatch($sformatf("has_piece %b, expected %b",
                                      rsp_ch.has_piece, want_piece.has_piece));
          end
          if (rsp_ch.end_of_call !== want_piece.end_of_call) begin
            report_mismatch($sformatf("end_of_call %b, expected %b",
                                      rsp_ch.end_of_call, want_piece.end_of_call));
          end
        end
      end
      rsp_ch.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  // Watchdog: a run that is still going long after the slowest correct run
  // would have ended is a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("range_set_subtract_unit verification failed");
      $finish;
    end
  end

  initial begin
    // Known values on every input from time zero; the shadow state matches
    // the block's state after reset, with no call open.
    rst               = 1'b1;
    req_ch.valid      = 1'b0;
    req_ch.func       = FUNC_BEGIN;
    req_ch.range_low  = '0;
    req_ch.range_high = '0;
    req_ch.last_item  = 1'b0;
    rsp_ch.ready      = 1'b0;
    run_low           = '0;
    tgt_high          = '0;
    used_up           = 1'b1;
    error_count       = 0;
    cycle_count       = 0;
    items_made        = 0;
    hold_trigger      = 1'b0;
    set_idle(IDLE_NONE);
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part. Right after reset no call is open, so a list range
    // alone sends nothing and a last one sends only an empty final.
    queue_range(FUNC_SUBTRACT, 32'd5, 32'd10, 1'b0);
    queue_range(FUNC_SUBTRACT, 32'd0, 32'd0, 1'b1);
    // A begin marked last returns the whole target, or an empty final if empty.
    queue_range(FUNC_BEGIN, 32'd10, 32'd20, 1'b1);
    queue_range(FUNC_BEGIN, 32'd20, 32'd10, 1'b1);
    // Full-width target: a list range starting at the bound leaves no gap, later
    // ones leave gaps, and one that ends at the top uses the target up
    // without wrapping, so the final result is empty.
    queue_range(FUNC_BEGIN, 32'd0, VALUE_MAX, 1'b0);
    queue_range(FUNC_SUBTRACT, 32'd0, 32'd5, 1'b0);
    queue_range(FUNC_SUBTRACT, 32'd10, 32'd20, 1'b0);
    queue_range(FUNC_SUBTRACT, 32'hffff_fff0, VALUE_MAX, 1'b1);
    // Reversed list range, then a range that runs past the target's end.
    queue_range(FUNC_BEGIN, 32'd100, 32'd200, 1'b0);
    queue_range(FUNC_SUBTRACT, 32'd150, 32'd120, 1'b0);
    queue_range(FUNC_SUBTRACT, 32'd300, 32'd400, 1'b1);
    // List range entirely below the target, and a remainder at the end.
    queue_range(FUNC_BEGIN, 32'd100, 32'd200, 1'b0);
    queue_range(FUNC_SUBTRACT, 32'd0, 32'd50, 1'b0);
    queue_range(FUNC_SUBTRACT, 32'd120, 32'd130, 1'b1);
    // After the last item the target stays used up until the next begin.
    queue_range(FUNC_SUBTRACT, 32'd0, 32'd5, 1'b0);
    queue_range(FUNC_SUBTRACT, 32'd0, 32'd5, 1'b1);
    // An empty target is used up at once.
    queue_range(FUNC_BEGIN, 32'd7, 32'd3, 1'b0);
    queue_range(FUNC_SUBTRACT, 32'd0, 32'd1, 1'b1);
    // A single-value target at the top survives a range just below it.
    queue_range(FUNC_BEGIN, VALUE_MAX, VALUE_MAX, 1'b0);
    queue_range(FUNC_SUBTRACT, 32'd0, 32'hffff_fffe, 1'b1);
    // A call left open is simply replaced by the next begin.
    queue_range(FUNC_BEGIN, 32'd5, 32'd5, 1'b0);
    queue_range(FUNC_BEGIN, 32'd1, 32'd2, 1'b1);
    wait_drained();

    // Random phases. The first runs without idling and, once traffic is
    // flowing, holds the receiver off long enough to back the block up.
    fill_phase(400);
    while (range_queue.size() > items_made - 60) begin
      @(negedge clk);
    end
    hold_trigger = 1'b1;
    @(negedge clk);
    hold_trigger = 1'b0;
    wait_drained();

    set_idle(IDLE_SENDER);
    fill_phase(430);
    wait_drained();

    set_idle(IDLE_RECEIVER);
    fill_phase(430);
    wait_drained();

    set_idle(IDLE_BOTH);
    fill_phase(430);
    wait_drained();

    // Let any stray result surface before the verdict.
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (pending_pieces.size() != 0) begin
      report_mismatch($sformatf("%0d expected results never arrived", pending_pieces.size()));
    end
    if (error_count == 0) begin
      $display("range_set_subtract_unit verification clean");
    end else begin
      $display("range_set_subtract_unit verification failed");
    end
    $finish;
  end

endmodule
